[sv/multi_column_key_crc32c_hash_assert.svh]
// Assertion macros for the multi-column key hash.
`ifndef MULTI_COLUMN_KEY_CRC32C_HASH_ASSERT_SVH
`define MULTI_COLUMN_KEY_CRC32C_HASH_ASSERT_SVH
`ifndef SYNTHESIS
`define MKH_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MKH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MKH_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MKH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[sv/mkh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mkh_pkg;

   localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;

   localparam logic KIND_INT  = 1'b0;
   localparam logic KIND_TEXT = 1'b1;

   localparam logic [1:0] INT_U8      = 2'd0;
   localparam logic [1:0] INT_S16     = 2'd1;
   localparam logic [1:0] INT_S32     = 2'd2;
   localparam logic [1:0] INT_S64_FLD = 2'd3;

   localparam int unsigned LANES = 8;
   localparam logic [3:0] MAX_BYTES  = 4'd8;
   localparam logic [3:0] WORD_BYTES = 4'd4;

   typedef struct packed {
      logic        kind;
      logic [63:0] value;
      logic [1:0]  int_size;
      logic [3:0]  byte_count;
      logic        is_null;
      logic        first_column;
      logic        last_chunk;
      logic        last_column;
   } req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] hash;
   } result_type;

   // CRC register contribution of each bit of a byte after byte_steps byte updates
   function automatic logic [7:0][31:0] shift_cols(input int unsigned byte_steps);
      logic [7:0][31:0] cols;
      logic [31:0]      v;
      for (int b = 0; b < 8; b++) begin
         v = 32'd1 << b;
         for (int unsigned k = 0; k < byte_steps * 8; k++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
         end
         cols[b] = v;
      end
      return cols;
   endfunction

endpackage

`default_nettype wire

[sv/mkh_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface mkh_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] value;
   logic [1:0]  int_size;
   logic [3:0]  byte_count;
   logic        is_null;
   logic        first_column;
   logic        last_chunk;
   logic        last_column;

   modport source (
      output valid, kind, value, int_size, byte_count, is_null, first_column,
             last_chunk, last_column,
      input  ready
   );
   modport sink (
      input  valid, kind, value, int_size, byte_count, is_null, first_column,
             last_chunk, last_column,
      output ready
   );
endinterface

interface mkh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] row_hash;

   modport source (output valid, row_hash, input ready);
   modport sink (input valid, row_hash, output ready);
endinterface

`default_nettype wire

[sv/mkh_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module mkh_lane #(
   parameter int unsigned BytePos = 0
) (
   input  logic [7:0]  lane_byte,
   output logic [31:0] lane_crc
);

   localparam logic [7:0][31:0] COLS = mkh_pkg::shift_cols(mkh_pkg::LANES - BytePos);

   always_comb begin
      lane_crc = '0;
      for (int b = 0; b < 8; b++) begin
         if (lane_byte[b]) begin
            lane_crc = lane_crc ^ COLS[b];
         end
      end
   end

endmodule

`default_nettype wire

[sv/mkh_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "multi_column_key_crc32c_hash_assert.svh"

module mkh_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_accept,
   input  mkh_pkg::req_type       req_item,
   output mkh_pkg::result_type    res
);

   logic [31:0] run_ff, run_in;
   logic        inside_ff, inside_in;

   logic [31:0]      int_word;
   logic [63:0]      data;
   logic [63:0]      data_masked;
   logic [3:0]       n_bytes;
   logic [3:0]       lead_bytes;
   logic [6:0]       shamt;
   logic [31:0]      start_crc;
   logic [95:0]      msg_word;
   logic [31:0]      crc_next;
   logic [7:0][31:0] lane_out;
   logic             closes;

   always_comb begin
      case (req_item.int_size)
         mkh_pkg::INT_U8:  int_word = {24'd0, req_item.value[7:0]};
         mkh_pkg::INT_S16: int_word = {{16{req_item.value[15]}}, req_item.value[15:0]};
         mkh_pkg::INT_S32: int_word = req_item.value[31:0];
         default:          int_word = req_item.value[31:0] ^
                              (req_item.value[63] ? ~req_item.value[63:32]
                                                  : req_item.value[63:32]);
      endcase
   end

   always_comb begin
      if (req_item.kind == mkh_pkg::KIND_TEXT) begin
         data      = req_item.value;
         n_bytes   = (req_item.byte_count > mkh_pkg::MAX_BYTES) ? mkh_pkg::MAX_BYTES
                                                               : req_item.byte_count;
         start_crc = (inside_ff || !req_item.first_column) ? run_ff : mkh_pkg::CRC_SEED;
      end else begin
         data      = {32'd0, int_word};
         n_bytes   = mkh_pkg::WORD_BYTES;
         start_crc = req_item.first_column ? mkh_pkg::CRC_SEED : run_ff;
      end
      for (int j = 0; j < 8; j++) begin
         data_masked[8*j +: 8] = (4'(j) < n_bytes) ? data[8*j +: 8] : 8'd0;
      end
      // right-align the bytes; leading zero bytes leave a zero state untouched
      lead_bytes = mkh_pkg::MAX_BYTES - n_bytes;
      shamt      = {lead_bytes, 3'd0};
      msg_word   = ({32'd0, data_masked << shamt}) ^ ({64'd0, start_crc} << shamt);
   end

   for (genvar g = 0; g < mkh_pkg::LANES; g++) begin : g_lane
      mkh_lane #(.BytePos(g)) u_lane (
         .lane_byte (msg_word[8*g +: 8]),
         .lane_crc  (lane_out[g])
      );
   end

   always_comb begin
      crc_next = msg_word[95:64];
      for (int j = 0; j < 8; j++) begin
         crc_next = crc_next ^ lane_out[j];
      end
   end

   always_comb begin
      run_in    = run_ff;
      inside_in = inside_ff;
      closes    = 1'b1;
      if (req_accept) begin
         if (req_item.is_null) begin
            run_in    = req_item.first_column ? 32'd0 : run_ff;
            inside_in = 1'b0;
         end else if (req_item.kind == mkh_pkg::KIND_INT) begin
            run_in    = crc_next;
            inside_in = 1'b0;
         end else begin
            run_in    = crc_next;
            inside_in = !req_item.last_chunk;
            closes    = req_item.last_chunk;
         end
      end
      res.valid = req_accept && closes && req_item.last_column;
      res.hash  = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= '0;
         inside_ff <= 1'b0;
      end else begin
         run_ff    <= run_in;
         inside_ff <= inside_in;
      end
   end

   `MKH_ASSERT_NEXT(a_null_first_clears, clock, reset, req_accept && req_item.is_null && req_item.first_column, run_ff == 32'd0, "null first column must clear the hash")
   `MKH_ASSERT_NEXT(a_int_closes_value, clock, reset, req_accept && !req_item.is_null && (req_item.kind == mkh_pkg::KIND_INT), !inside_ff, "integer item must close any open text value")
   `MKH_ASSERT_NEXT(a_empty_first_text, clock, reset, req_accept && !req_item.is_null && (req_item.kind == mkh_pkg::KIND_TEXT) && req_item.first_column && !inside_ff && (req_item.byte_count == 4'd0), run_ff == mkh_pkg::CRC_SEED, "empty first text must leave the seed")

endmodule

`default_nettype wire

[sv/mkh_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "multi_column_key_crc32c_hash_assert.svh"

module mkh_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  mkh_pkg::result_type res,
   output logic                buf_ready,
   mkh_rsp_if.source           rsp_ch
);

   logic [31:0] head_ff, head_in;
   logic [31:0] tail_ff, tail_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        pop;

   assign buf_ready       = (cnt_ff != 2'd2);
   assign rsp_ch.valid    = (cnt_ff != 2'd0);
   assign rsp_ch.row_hash = head_ff;
   assign pop             = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case ({res.valid, pop})
         2'b10: begin
            if (cnt_ff == 2'd0) begin
               head_in = res.hash;
            end else begin
               tail_in = res.hash;
            end
            cnt_in = cnt_ff + 2'd1;
         end
         2'b01: begin
            head_in = tail_ff;
            cnt_in  = cnt_ff - 2'd1;
         end
         2'b11: begin
            if (cnt_ff == 2'd1) begin
               head_in = res.hash;
            end else begin
               head_in = tail_ff;
               tail_in = res.hash;
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `MKH_ASSERT_IMP(a_no_push_when_full, clock, reset, res.valid, cnt_ff != 2'd2, "item pushed into a full buffer")
   `MKH_ASSERT_NEXT(a_pop_from_full, clock, reset, pop && !res.valid && (cnt_ff == 2'd2), cnt_ff == 2'd1, "pop from a full buffer lost count")
   `MKH_ASSERT_NEXT(a_push_to_empty, clock, reset, res.valid && (cnt_ff == 2'd0), rsp_ch.valid && (head_ff == $past(res.hash)), "item into empty buffer not presented")

endmodule

`default_nettype wire

[sv/multi_column_key_crc32c_hash.sv]
`timescale 1ns / 1ps
`default_nettype none

// Row hash for multi-column join keys, CRC32C (Castagnoli) from seed 0xFFFFFFFF with
// no final inversion. One item per clock is taken while req_ch.ready is high: an
// integer column value, a text chunk of up to eight bytes, or a null. The hash
// update for an item is done in the same cycle it is accepted by eight byte lanes
// whose results are XOR-merged, so the running hash is ready for the next item on
// the following clock; this feedback through the lanes sets the rate at one item
// per cycle. A row's hash is written into the two-entry output buffer and reaches
// rsp_ch from its head register. The buffer lets input continue while one result
// waits; req_ch.ready drops only when both entries are full.
module multi_column_key_crc32c_hash (
   input  wire        clock,
   input  wire        reset,
   mkh_req_if.sink    req_ch,
   mkh_rsp_if.source  rsp_ch
);

   mkh_pkg::req_type    req_item;
   mkh_pkg::result_type res;
   logic                buf_ready;
   logic                req_accept;

   assign req_ch.ready = buf_ready;
   assign req_accept   = req_ch.valid && buf_ready;

   assign req_item.kind         = req_ch.kind;
   assign req_item.value        = req_ch.value;
   assign req_item.int_size     = req_ch.int_size;
   assign req_item.byte_count   = req_ch.byte_count;
   assign req_item.is_null      = req_ch.is_null;
   assign req_item.first_column = req_ch.first_column;
   assign req_item.last_chunk   = req_ch.last_chunk;
   assign req_item.last_column  = req_ch.last_column;

   mkh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_item),
      .res        (res)
   );

   mkh_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .buf_ready (buf_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int MAX_REPORTS = 10;
   localparam int LONG_HOLD   = 300;
   localparam int ROWS_HELD   = 40;

   logic clock;
   logic reset;

   mkh_req_if req_ch ();
   mkh_rsp_if rsp_ch ();

   multi_column_key_crc32c_hash i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   logic [31:0] row_hash_expected[$];
   logic [31:0] hash_acc;
   logic        text_open;

   int items_sent;
   int hashes_checked;
   int mismatch_count;
   int rsp_hold_req;
   int burst_left;
   bit sender_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ mkh_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic logic [31:0] int_column_word(input logic [63:0] v, input logic [1:0] size);
      case (size)
         mkh_pkg::INT_U8:  return {24'd0, v[7:0]};
         mkh_pkg::INT_S16: return {{16{v[15]}}, v[15:0]};
         mkh_pkg::INT_S32: return v[31:0];
         default:          return v[31:0] ^ (v[63] ? ~v[63:32] : v[63:32]);
      endcase
   endfunction

   function automatic void predict_row_hash(input mkh_pkg::req_type it);
      logic [31:0] crc;
      logic [31:0] w;
      logic [3:0]  n;
      logic        closes;
      closes = 1'b1;
      if (it.is_null) begin
         if (it.first_column) hash_acc = '0;
         text_open = 1'b0;
      end else if (it.kind == mkh_pkg::KIND_INT) begin
         crc = it.first_column ? mkh_pkg::CRC_SEED : hash_acc;
         w = int_column_word(it.value, it.int_size);
         for (int k = 0; k < 4; k++) crc = crc32c_byte(crc, w[8*k +: 8]);
         hash_acc = crc;
         text_open = 1'b0;
      end else begin
         n = (it.byte_count > mkh_pkg::MAX_BYTES) ? mkh_pkg::MAX_BYTES : it.byte_count;
         crc = (text_open || !it.first_column) ? hash_acc : mkh_pkg::CRC_SEED;
         for (int k = 0; k < 8; k++) begin
            if (k < n) crc = crc32c_byte(crc, it.value[8*k +: 8]);
         end
         hash_acc = crc;
         text_open = !it.last_chunk;
         closes = it.last_chunk;
      end
      if (closes && it.last_column) row_hash_expected.push_back(hash_acc);
   endfunction

   function automatic mkh_pkg::req_type random_fields();
      mkh_pkg::req_type it;
      it.kind         = 1'($urandom_range(0, 1));
      it.value        = {$urandom, $urandom};
      it.int_size     = 2'($urandom_range(0, 3));
      it.byte_count   = 4'($urandom_range(0, 15));
      it.is_null      = 1'($urandom_range(0, 1));
      it.first_column = 1'($urandom_range(0, 1));
      it.last_chunk   = 1'($urandom_range(0, 1));
      it.last_column  = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic mkh_pkg::req_type mk_int(input logic [1:0] size, input logic [63:0] v,
                                               input logic first, input logic last);
      mkh_pkg::req_type it;
      it = random_fields();
      it.kind = mkh_pkg::KIND_INT;
      it.is_null = 1'b0;
      it.int_size = size;
      it.value = v;
      it.first_column = first;
      it.last_column = last;
      return it;
   endfunction

   function automatic mkh_pkg::req_type mk_text(input logic [63:0] v, input logic [3:0] count,
                                                input logic first, input logic lc,
                                                input logic last);
      mkh_pkg::req_type it;
      it = random_fields();
      it.kind = mkh_pkg::KIND_TEXT;
      it.is_null = 1'b0;
      it.value = v;
      it.byte_count = count;
      it.first_column = first;
      it.last_chunk = lc;
      it.last_column = last;
      return it;
   endfunction

   function automatic mkh_pkg::req_type mk_null(input logic first, input logic last);
      mkh_pkg::req_type it;
      it = random_fields();
      it.is_null = 1'b1;
      it.first_column = first;
      it.last_column = last;
      return it;
   endfunction

   task automatic send_item(input mkh_pkg::req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 6) : 0;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.kind         <= it.kind;
      req_ch.value        <= it.value;
      req_ch.int_size     <= it.int_size;
      req_ch.byte_count   <= it.byte_count;
      req_ch.is_null      <= it.is_null;
      req_ch.first_column <= it.first_column;
      req_ch.last_chunk   <= it.last_chunk;
      req_ch.last_column  <= it.last_column;
      req_ch.valid        <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_row_hash(it);
      items_sent++;
   endtask

   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (row_hash_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_random_row();
      mkh_pkg::req_type it;
      int               ncols;
      int               nchunks;
      int               sel;
      ncols = $urandom_range(1, 4);
      for (int c = 0; c < ncols; c++) begin
         it = random_fields();
         it.first_column = (c == 0);
         it.last_column = (c == ncols - 1);
         sel = $urandom_range(0, 99);
         if (sel < 10) begin
            it.is_null = 1'b1;
            send_item(it);
         end else if (sel < 55) begin
            it.is_null = 1'b0;
            it.kind = mkh_pkg::KIND_INT;
            send_item(it);
         end else begin
            nchunks = $urandom_range(1, 3);
            for (int k = 0; k < nchunks; k++) begin
               it.kind = mkh_pkg::KIND_TEXT;
               it.is_null = 1'b0;
               it.value = {$urandom, $urandom};
               it.int_size = 2'($urandom_range(0, 3));
               it.byte_count = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                           : 4'($urandom_range(0, 8));
               it.last_chunk = (k == nchunks - 1);
               if (k > 0) it.first_column = 1'($urandom_range(0, 1));
               send_item(it);
            end
         end
      end
   endtask

   task automatic test_integer_sizes();
      send_item(mk_int(mkh_pkg::INT_U8,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S16,     64'h1234_5678_9ABC_8000, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S16,     64'hFFFF_FFFF_FFFF_7FFF, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S32,     64'hFFFF_FFFF_8000_0000, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S64_FLD, 64'h8000_0000_0000_0001, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S64_FLD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
      send_item(mk_int(mkh_pkg::INT_U8,      64'h0,                   1'b1, 1'b1));
   endtask

   task automatic test_text_chunks();
      send_item(mk_text(64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  1'b1, 1'b1, 1'b1));
      send_item(mk_text(64'hDEAD_BEEF_0123_4567, 4'd0,  1'b1, 1'b1, 1'b1));
      send_item(mk_text(64'h0102_0304_0506_0708, 4'd15, 1'b1, 1'b1, 1'b1));
      send_item(mk_text(64'hAAAA_AAAA_AA61_6263, 4'd3,  1'b1, 1'b0, 1'b1));
      send_item(mk_text(64'h5555_5555_5555_5555, 4'd8,  1'b1, 1'b1, 1'b1));
      send_item(mk_text(64'h0000_0070_6F6E_6D6C, 4'd5,  1'b1, 1'b0, 1'b0));
      send_item(mk_text(64'h1122_3344_5566_7788, 4'd0,  1'b0, 1'b1, 1'b0));
      send_item(mk_int(mkh_pkg::INT_S16, 64'h0000_0000_0000_FFFE, 1'b0, 1'b1));
   endtask

   task automatic test_null_columns();
      send_item(mk_null(1'b1, 1'b1));
      send_item(mk_null(1'b1, 1'b0));
      send_item(mk_int(mkh_pkg::INT_S32, 64'h0000_0000_1234_5678, 1'b0, 1'b1));
      send_item(mk_int(mkh_pkg::INT_S64_FLD, 64'hFEDC_BA98_7654_3210, 1'b1, 1'b0));
      send_item(mk_null(1'b0, 1'b1));
   endtask

   task automatic test_interrupted_text();
      send_item(mk_text(64'h6867_6665_6463_6261, 4'd8, 1'b1, 1'b0, 1'b0));
      send_item(mk_int(mkh_pkg::INT_U8, 64'h0000_0000_0000_0080, 1'b0, 1'b1));
      send_item(mk_text(64'h0000_0000_0000_7A79, 4'd2, 1'b1, 1'b0, 1'b1));
      send_item(mk_null(1'b0, 1'b1));
   endtask

   task automatic test_random_rows(input int n_items);
      int target;
      int nnoise;
      target = items_sent + n_items;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) == 0) begin
            nnoise = $urandom_range(1, 3);
            repeat (nnoise) send_item(random_fields());
         end else begin
            send_random_row();
         end
      end
   endtask

   task automatic test_output_backpressure();
      sender_gaps = 1'b0;
      rsp_hold_req = LONG_HOLD;
      repeat (ROWS_HELD) send_item(mk_int(2'($urandom_range(0, 3)), {$urandom, $urandom},
                                          1'b1, 1'b1));
      sender_gaps = 1'b1;
   endtask

   initial begin
      int hold_left;
      int mode;
      int phase_cnt;
      logic [31:0] want;
      hold_left = 0;
      mode = 0;
      phase_cnt = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         phase_cnt++;
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (row_hash_expected.size() == 0) begin
               if (mismatch_count < MAX_REPORTS)
                  $display("row_hash %08h with no row pending", rsp_ch.row_hash);
               mismatch_count++;
            end else begin
               want = row_hash_expected.pop_front();
               hashes_checked++;
               if (rsp_ch.row_hash !== want) begin
                  if (mismatch_count < MAX_REPORTS)
                     $display("row_hash mismatch: expected %08h, actual %08h",
                              want, rsp_ch.row_hash);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold_req > 0) begin
            hold_left = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_ch.ready <= 1'b1;
               1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_ch.ready <= ((phase_cnt % 4) != 3);
               default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   initial begin
      items_sent = 0;
      hashes_checked = 0;
      mismatch_count = 0;
      rsp_hold_req = 0;
      burst_left = 0;
      sender_gaps = 1'b1;
      hash_acc = '0;
      text_open = 1'b0;
      reset <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.kind         <= mkh_pkg::KIND_INT;
      req_ch.value        <= '0;
      req_ch.int_size     <= mkh_pkg::INT_U8;
      req_ch.byte_count   <= '0;
      req_ch.is_null      <= 1'b0;
      req_ch.first_column <= 1'b0;
      req_ch.last_chunk   <= 1'b0;
      req_ch.last_column  <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_integer_sizes();
      test_text_chunks();
      test_null_columns();
      test_interrupted_text();
      test_random_rows(220);
      pause_until_drained();
      test_output_backpressure();
      test_random_rows(260);
      pause_until_drained();
      repeat (8) @(posedge clock);

      if (row_hash_expected.size() != 0) mismatch_count += row_hash_expected.size();
      $display("Sent %0d items and checked %0d row hashes: all integer widths, text chunks,",
               items_sent, hashes_checked);
      $display("nulls, broken text values and a %0d-cycle output stall.", LONG_HOLD);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
